FILE: design/csem_pkg.sv
// Shared types and constants for the counting semaphore table.
// No dependencies; imported by every module of the block.
package csem_pkg;

   // Width of one semaphore count (two's complement)
   localparam int COUNT_W = 16;

   // Slots covered by one group of the free-slot finder
   localparam int GRP_SIZE = 8;
   localparam int GRP_W    = 3;

   // Largest count; post saturates here
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7FFF;

   // Operation codes
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_WAIT  = 2'd2,
      OP_POST  = 2'd3
   } op_type;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_BLOCK   = 2'd3;

endpackage

FILE: design/csem_count_ram.sv
// Count memory: one 16-bit count per slot, one read and one write port.
// Read data is registered. Depends on csem_pkg.
module csem_count_ram
   import csem_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   output logic [COUNT_W-1:0]         rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  logic [COUNT_W-1:0]         wr_data
);

   logic [COUNT_W-1:0] mem [SLOTS];
   logic [COUNT_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/csem_free_finder.sv
// Two-step lowest-free-slot search over the in-use bits.
// Step one registers a per-group summary, step two picks the lowest group.
// Depends on csem_pkg.
module csem_free_finder
   import csem_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       capture,
   input  logic [SLOTS-1:0]           free_vec,
   output logic                       found,
   output logic [$clog2(SLOTS)-1:0]   slot
);

   localparam int SW     = $clog2(SLOTS);
   localparam int GROUPS = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_W  = GROUPS * GRP_SIZE;

   logic [PAD_W-1:0]  free_pad;
   logic [GROUPS-1:0] grp_any_in;
   logic [GROUPS-1:0] grp_any_ff;
   logic [GRP_W-1:0]  grp_idx_in [GROUPS];
   logic [GRP_W-1:0]  grp_idx_ff [GROUPS];
   logic [GW-1:0]     grp_sel;
   logic [GW+GRP_W-1:0] pick;

   // Slots past the end of the table never read as free
   assign free_pad = PAD_W'(free_vec);

   // Per-group summary: any free slot and the lowest one inside the group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = |free_pad[g*GRP_SIZE +: GRP_SIZE];
         grp_idx_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (free_pad[g*GRP_SIZE + b]) begin
               grp_idx_in[g] = GRP_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   // Lowest group that has a free slot
   always_comb begin
      grp_sel = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            grp_sel = GW'(g);
         end
      end
   end

   assign found = |grp_any_ff;
   assign pick  = {grp_sel, grp_idx_ff[grp_sel]};
   assign slot  = pick[SW-1:0];

endmodule

FILE: design/counting_semaphore_table.sv
// Counting semaphore table: a bank of SLOTS semaphores (in-use bit and count).
//
// Request channel (req_valid/req_ready): req_op selects alloc, free, wait or
// post; req_sem_id names the slot for free/wait/post; req_init_value is the
// starting count for alloc. Response channel (rsp_valid/rsp_ready) returns
// one transaction per request: rsp_status, rsp_granted_id, rsp_count_after.
//
// A request is accepted in ST_IDLE, which reads the count memory and registers
// the free-slot summary; in ST_EXEC the block modifies the count, writes it
// back and loads the response register. A new request is not accepted until
// the previous one has left ST_EXEC.
//
// A request may be accepted while the previous response waits. If the
// response register is still full when the next request finishes, the block
// holds that request until rsp_ready frees the register.
//
// Reset clears all in-use bits at once; the count memory is not cleared,
// since a count is only used for a slot in use. Depends on csem_pkg,
// csem_count_ram and csem_free_finder.
module counting_semaphore_table
   import csem_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_op,
   input  logic [6:0]   req_sem_id,
   input  logic [15:0]  req_init_value,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic [5:0]   rsp_granted_id,
   output logic [15:0]  rsp_count_after
);

   localparam int SW = $clog2(SLOTS);
   localparam int XW = (SW > 6) ? SW : 6;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff;
   logic [SW-1:0]       slot_ff;
   logic                id_ok_ff;
   logic [COUNT_W-1:0]  init_ff;
   logic [SLOTS-1:0]    in_use_ff, in_use_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [5:0]          rsp_gid_ff, rsp_gid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                complete;
   logic                in_range;
   logic                found;
   logic [SW-1:0]       free_slot;
   logic [XW-1:0]       gid_ext;
   logic [COUNT_W-1:0]  rd_data;
   logic                wr_en;
   logic [SW-1:0]       wr_addr;
   logic [COUNT_W-1:0]  wr_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign complete  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign in_range  = ({1'b0, req_sem_id} < 8'(SLOTS));
   assign gid_ext   = XW'(free_slot);

   csem_count_ram #(.SLOTS(SLOTS)) u_count_ram (
      .clock   (clock),
      .rd_en   (accept && in_range),
      .rd_addr (req_sem_id[SW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   csem_free_finder #(.SLOTS(SLOTS)) u_free_finder (
      .clock    (clock),
      .capture  (accept),
      .free_vec (~in_use_ff),
      .found    (found),
      .slot     (free_slot)
   );

   // Modify step: result, count write-back and in-use update
   always_comb begin
      state_in      = state_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_gid_in    = rsp_gid_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = rd_data;

      if (accept) begin
         state_in = ST_EXEC;
      end

      if (complete) begin
         state_in      = ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_gid_in    = '0;
         rsp_count_in  = '0;
         if (op_ff == OP_ALLOC) begin
            if (found) begin
               in_use_in[free_slot] = 1'b1;
               wr_en        = 1'b1;
               wr_addr      = free_slot;
               wr_data      = init_ff;
               rsp_gid_in   = gid_ext[5:0];
               rsp_count_in = init_ff;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end else if (!id_ok_ff) begin
            rsp_status_in = ST_INVALID;
         end else begin
            unique case (op_ff)
               OP_FREE: begin
                  in_use_in[slot_ff] = 1'b0;
               end
               OP_WAIT: begin
                  if (rd_data[COUNT_W-1] || rd_data == '0) begin
                     rsp_status_in = ST_BLOCK;
                     rsp_count_in  = rd_data;
                  end else begin
                     wr_en        = 1'b1;
                     wr_data      = rd_data - COUNT_W'(1);
                     rsp_count_in = rd_data - COUNT_W'(1);
                  end
               end
               OP_POST: begin
                  wr_en = 1'b1;
                  if (rd_data != COUNT_MAX) begin
                     wr_data = rd_data + COUNT_W'(1);
                  end
                  rsp_count_in = wr_data;
               end
               default: begin
                  rsp_count_in = '0;
               end
            endcase
         end
      end
   end

   // State, captured request and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_gid_ff    <= rsp_gid_in;
         rsp_count_ff  <= rsp_count_in;
         if (accept) begin
            op_ff    <= op_type'(req_op);
            slot_ff  <= req_sem_id[SW-1:0];
            id_ok_ff <= in_range && in_use_ff[req_sem_id[SW-1:0]];
            init_ff  <= req_init_value;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_granted_id  = rsp_gid_ff;
   assign rsp_count_after = rsp_count_ff;

`ifndef SYNTHESIS
   // A response only appears as the modify step finishes
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response appeared without a finished request");

   // Alloc never hands out a slot that is already in use
   a_alloc_free_slot: assert property (@(posedge clock) disable iff (reset)
      (complete && op_ff == OP_ALLOC && found) |-> !in_use_ff[free_slot])
      else $error("alloc granted a slot in use");

   // Would-block only reports a count of zero or below
   a_block_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BLOCK) |->
         (rsp_count_after[15] || rsp_count_after == 16'd0))
      else $error("would-block on a positive count");

   // Failed requests carry zero id and zero count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INVALID || rsp_status == ST_FULL)) |->
         (rsp_granted_id == 6'd0 && rsp_count_after == 16'd0))
      else $error("failed request returned nonzero fields");
`endif

endmodule

FILE: tb/counting_semaphore_table_tb.sv
// Testbench for counting_semaphore_table: drives alloc/free/wait/post requests
// and checks every response against an in-bench semaphore bank predictor.
// Depends on csem_pkg and the counting_semaphore_table RTL only.
`timescale 1ns / 100ps

module counting_semaphore_table_tb;
   import csem_pkg::*;

   localparam int SLOTS      = 64;
   localparam int LIMIT      = 400000;
   localparam int TAIL_WAIT  = 8;

   typedef struct {
      op_type             op;
      logic [6:0]         sem_id;
      logic signed [15:0] init_value;
      bit                 drain;      // hold off until nothing is outstanding
   } sem_req_type;

   typedef struct {
      logic [1:0]         status;
      logic [5:0]         granted_id;
      logic signed [15:0] count_after;
   } sem_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = OP_ALLOC;
   logic [6:0]         req_sem_id = 7'd0;
   logic [15:0]        req_init_value = 16'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_granted_id;
   logic [15:0]        rsp_count_after;

   // predictor copy of the bank
   bit                 sem_busy [SLOTS];
   logic signed [15:0] sem_count [SLOTS];

   sem_req_type        request_q [$];
   sem_result_type     outcome_q [$];
   sem_req_type        cur_req;
   int                 stim_total;
   int                 n_accepted;
   int                 n_errors;
   int                 n_cycles;

   counting_semaphore_table #(.SLOTS(SLOTS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sem_id      (req_sem_id),
      .req_init_value  (req_init_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_granted_id  (rsp_granted_id),
      .rsp_count_after (rsp_count_after)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bank update for one accepted request; returns the response it must give
   function automatic sem_result_type apply_request(sem_req_type r);
      sem_result_type res;
      int             slot;
      res  = '{ST_OK, 6'd0, 16'sd0};
      slot = -1;
      if (r.op == OP_ALLOC) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (!sem_busy[s] && slot < 0) slot = s;
         end
         if (slot < 0) begin
            res.status = ST_FULL;
         end else begin
            sem_busy[slot]  = 1'b1;
            sem_count[slot] = r.init_value;
            res.granted_id  = slot[5:0];
            res.count_after = r.init_value;
         end
      end else if (r.sem_id >= SLOTS || !sem_busy[r.sem_id]) begin
         res.status = ST_INVALID;
      end else begin
         slot = r.sem_id;
         case (r.op)
            OP_FREE: begin
               sem_busy[slot]  = 1'b0;
               sem_count[slot] = '0;
            end
            OP_WAIT: begin
               // never sleeps: non-positive count reports would-block
               if (sem_count[slot] <= 0) begin
                  res.status = ST_BLOCK;
               end else begin
                  sem_count[slot] = sem_count[slot] - 16'sd1;
               end
               res.count_after = sem_count[slot];
            end
            default: begin
               // post saturates at the top count
               if (sem_count[slot] != COUNT_MAX) sem_count[slot] = sem_count[slot] + 16'sd1;
               res.count_after = sem_count[slot];
            end
         endcase
      end
      return res;
   endfunction

   // Idle rates per phase of the run
   function automatic int send_idle_pct();
      if (n_accepted < stim_total / 3) return 33;
      if (n_accepted < (2 * stim_total) / 3) return 74;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (n_accepted < stim_total / 3) return 74;
      if (n_accepted < (2 * stim_total) / 3) return 33;
      return 0;
   endfunction

   task automatic queue_request(op_type op, int id, int init, bit drain);
      sem_req_type r;
      r.op         = op;
      r.sem_id     = id[6:0];
      r.init_value = init[15:0];
      r.drain      = drain;
      request_q.push_back(r);
   endtask

   function automatic int pick_init();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) return int'($urandom_range(0, 6)) - 3;
      if (k < 60) begin
         case ($urandom_range(0, 4))
            0: return 32767;
            1: return 32766;
            2: return -32768;
            3: return -32767;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   task automatic report_mismatch(string field, int expv, int actv);
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
   endtask

   // Driver: presents queued requests, predicts each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(apply_request(cur_req));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 && !(request_q[0].drain && outcome_q.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct()) begin
               cur_req = request_q.pop_front();
               req_valid      <= 1'b1;
               req_op         <= cur_req.op;
               req_sem_id     <= cur_req.sem_id;
               req_init_value <= cur_req.init_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response transaction against the oldest prediction
   always @(posedge clock) begin
      sem_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected response, status %0d id %0d count %0d", $time,
                        rsp_status, rsp_granted_id, $signed(rsp_count_after));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_granted_id !== want.granted_id)
                  report_mismatch("granted_id", want.granted_id, rsp_granted_id);
               if (rsp_count_after !== want.count_after)
                  report_mismatch("count_after", want.count_after, $signed(rsp_count_after));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
   end

   // Watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles >= LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int kind;
      int len;
      int start;
      int stride;
      int hi;
      int w;
      int id;
      n_accepted = 0;
      n_errors   = 0;
      n_cycles   = 0;
      stim_total = 2000;
      foreach (sem_busy[i]) begin
         sem_busy[i]  = 1'b0;
         sem_count[i] = '0;
      end

      // Directed: invalid ids, extremes, saturation, blocking, slot reuse
      queue_request(OP_POST,  0,   0,      0);  // unused slot
      queue_request(OP_WAIT,  127, 0,      0);  // out of range
      queue_request(OP_FREE,  64,  -1,     0);  // first id past the end
      queue_request(OP_ALLOC, 99,  32767,  0);  // slot 0 at top count
      queue_request(OP_POST,  0,   0,      0);  // saturates
      queue_request(OP_WAIT,  0,   0,      0);
      queue_request(OP_ALLOC, 0,   -32768, 0);  // slot 1 at bottom count
      queue_request(OP_WAIT,  1,   0,      0);  // blocks on negative
      queue_request(OP_POST,  1,   0,      0);
      queue_request(OP_ALLOC, 127, 0,      0);  // slot 2 at zero
      queue_request(OP_WAIT,  2,   0,      0);  // blocks on zero
      queue_request(OP_POST,  2,   0,      0);
      queue_request(OP_WAIT,  2,   0,      0);  // back down to zero
      queue_request(OP_FREE,  1,   0,      1);  // after a full drain
      queue_request(OP_ALLOC, 5,   1,      0);  // reuses slot 1
      queue_request(OP_FREE,  1,   0,      0);
      queue_request(OP_FREE,  1,   0,      0);  // already freed
      queue_request(OP_WAIT,  1,   0,      0);  // freed slot
      queue_request(OP_POST,  1,   0,      0);
      queue_request(OP_ALLOC, 0,   -1,     0);
      queue_request(OP_WAIT,  63,  0,      0);  // last slot, unused
      queue_request(OP_FREE,  0,   0,      0);

      // Random episodes; the first always fills the bank past full
      kind = 0;
      while (request_q.size() < stim_total) begin
         if (kind < 12) begin
            len = 64 + $urandom_range(2, 6);
            for (int i = 0; i < len; i++)
               queue_request(OP_ALLOC, $urandom_range(0, 127), pick_init(),
                             i == 0 && $urandom_range(0, 9) == 0);
         end else if (kind < 24) begin
            // release every slot in a scrambled order
            start  = $urandom_range(0, 63);
            stride = 2 * $urandom_range(0, 31) + 1;
            for (int i = 0; i < SLOTS; i++)
               queue_request(OP_FREE, (start + i * stride) % SLOTS, $urandom,
                             i == 0 && $urandom_range(0, 9) == 0);
         end else if (kind < 88) begin
            // mixed traffic focused on a window of low slots
            len = $urandom_range(20, 40);
            hi  = $urandom_range(3, 63);
            for (int i = 0; i < len; i++) begin
               w  = $urandom_range(0, 99);
               id = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 127)
                                                 : $urandom_range(0, hi);
               queue_request(w < 15 ? OP_ALLOC : w < 25 ? OP_FREE : w < 65 ? OP_WAIT : OP_POST,
                             id, pick_init(), i == 0 && $urandom_range(0, 9) == 0);
            end
         end else begin
            // noise
            for (int i = 0; i < 10; i++)
               queue_request(op_type'($urandom_range(0, 3)), $urandom_range(0, 127),
                             $urandom, 1'b0);
         end
         kind = $urandom_range(0, 99);
      end
      stim_total = request_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < stim_total || outcome_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (n_errors == 0 && outcome_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: counting_semaphore_table.f
design/csem_pkg.sv
design/csem_count_ram.sv
design/csem_free_finder.sv
design/counting_semaphore_table.sv
tb/counting_semaphore_table_tb.sv
